### rtl/core/bounded_shifting_list_unit_defines.svh
`ifndef BOUNDED_SHIFTING_LIST_UNIT_DEFINES_SVH
`define BOUNDED_SHIFTING_LIST_UNIT_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define BSL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked while out of reset
`define BSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/bsl_pkg.sv
package bsl_pkg;

    localparam int DEPTH     = 256;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int CMD_BITS  = 3;
    localparam int POS_BITS  = 8;
    localparam int STAT_BITS = 2;
    localparam int CAP_BITS  = 9;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(256);

    typedef logic signed [WORD_BITS-1:0] t_word;

    // commands
    localparam logic [CMD_BITS-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_WRITE  = 3'd4;

    // result status
    localparam logic [STAT_BITS-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_POS  = 2'd2;

    // read address select
    localparam logic [2:0] RA_POS    = 3'd0;
    localparam logic [2:0] RA_POS_P1 = 3'd1;
    localparam logic [2:0] RA_CNT_M1 = 3'd2;
    localparam logic [2:0] RA_IDX_M2 = 3'd3;
    localparam logic [2:0] RA_IDX_P2 = 3'd4;

    // write address select
    localparam logic [1:0] WA_POS = 2'd0;
    localparam logic [1:0] WA_CNT = 2'd1;
    localparam logic [1:0] WA_IDX = 2'd2;

    // shift index update
    localparam logic [2:0] IDX_HOLD   = 3'd0;
    localparam logic [2:0] IDX_LD_CNT = 3'd1;
    localparam logic [2:0] IDX_LD_POS = 3'd2;
    localparam logic [2:0] IDX_DEC    = 3'd3;
    localparam logic [2:0] IDX_INC    = 3'd4;

    typedef struct packed {
        logic                 capture;
        logic                 rd_en;
        logic [2:0]           rd_sel;
        logic                 wr_en;
        logic [1:0]           wr_sel;
        logic                 wr_from_mem;
        logic [2:0]           idx_op;
        logic                 cnt_inc;
        logic                 cnt_dec;
        logic                 res_clr;
        logic                 res_cap;
        logic                 stat_set;
        logic [STAT_BITS-1:0] stat_code;
        logic                 out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_BITS-1:0] cmd;
        logic                full;
        logic                pos_gt_cnt;
        logic                pos_ge_cnt;
        logic                ins_last;
        logic                rm_more;
        logic                rm_last;
    } t_dp_stat;

endpackage

### rtl/core/bsl_datapath.sv
module bsl_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bsl_pkg::t_dp_cmd                    i_ctl,
    output bsl_pkg::t_dp_stat                   o_stat,
    input  logic                                i_cfg_valid,
    input  logic [bsl_pkg::CAP_BITS-1:0]        i_cfg_data,
    input  logic [bsl_pkg::CMD_BITS-1:0]        i_command,
    input  logic [bsl_pkg::POS_BITS-1:0]        i_position,
    input  bsl_pkg::t_word                      i_value,
    output bsl_pkg::t_word                      o_data,
    output logic [bsl_pkg::STAT_BITS-1:0]       o_status,
    output logic [bsl_pkg::CNT_BITS-1:0]        o_count,
    output logic                                o_full_res,
    output logic                                o_empty_res
);

    localparam int CW = bsl_pkg::CNT_BITS;
    localparam int AW = bsl_pkg::ADDR_BITS;

    bsl_pkg::t_word r_mem [bsl_pkg::DEPTH];

    logic [bsl_pkg::CAP_BITS-1:0]  r_cap;
    logic [bsl_pkg::CMD_BITS-1:0]  r_cmd;
    logic [bsl_pkg::POS_BITS-1:0]  r_pos;
    bsl_pkg::t_word                r_val;
    logic [CW-1:0]                 r_cnt;
    logic [CW-1:0]                 r_idx;
    logic [CW-1:0]                 n_idx;
    bsl_pkg::t_word                r_rd_data;
    bsl_pkg::t_word                r_res_data;
    logic [bsl_pkg::STAT_BITS-1:0] r_res_status;
    bsl_pkg::t_word                r_out_data;
    logic [bsl_pkg::STAT_BITS-1:0] r_out_status;
    logic [CW-1:0]                 r_out_count;
    logic                          r_out_full;
    logic                          r_out_empty;

    logic [CW-1:0]  pos_ext;
    logic [CW-1:0]  rd_addr_w;
    logic [CW-1:0]  wr_addr_w;
    bsl_pkg::t_word wr_data;
    logic           is_full;

    assign pos_ext = {1'b0, r_pos};
    assign is_full = (r_cnt >= r_cap) || (r_cnt >= CW'(bsl_pkg::DEPTH));

    always_comb begin
        case (i_ctl.rd_sel)
            bsl_pkg::RA_POS:    rd_addr_w = pos_ext;
            bsl_pkg::RA_POS_P1: rd_addr_w = pos_ext + CW'(1);
            bsl_pkg::RA_CNT_M1: rd_addr_w = r_cnt - CW'(1);
            bsl_pkg::RA_IDX_M2: rd_addr_w = r_idx - CW'(2);
            bsl_pkg::RA_IDX_P2: rd_addr_w = r_idx + CW'(2);
            default:            rd_addr_w = pos_ext;
        endcase
    end

    always_comb begin
        case (i_ctl.wr_sel)
            bsl_pkg::WA_POS: wr_addr_w = pos_ext;
            bsl_pkg::WA_CNT: wr_addr_w = r_cnt;
            bsl_pkg::WA_IDX: wr_addr_w = r_idx;
            default:         wr_addr_w = pos_ext;
        endcase
    end

    assign wr_data = i_ctl.wr_from_mem ? r_rd_data : r_val;

    always_comb begin
        case (i_ctl.idx_op)
            bsl_pkg::IDX_LD_CNT: n_idx = r_cnt;
            bsl_pkg::IDX_LD_POS: n_idx = pos_ext;
            bsl_pkg::IDX_DEC:    n_idx = r_idx - CW'(1);
            bsl_pkg::IDX_INC:    n_idx = r_idx + CW'(1);
            default:             n_idx = r_idx;
        endcase
    end

    // single write port, single registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[wr_addr_w[AW-1:0]] <= wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[rd_addr_w[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= bsl_pkg::CAP_RESET;
            r_cnt <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            if (i_ctl.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_ctl.cnt_dec) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd <= i_command;
            r_pos <= i_position;
            r_val <= i_value;
        end
        r_idx <= n_idx;
        if (i_ctl.res_clr) begin
            r_res_data <= '0;
        end else if (i_ctl.res_cap) begin
            r_res_data <= r_rd_data;
        end
        if (i_ctl.stat_set) begin
            r_res_status <= i_ctl.stat_code;
        end
        if (i_ctl.out_load) begin
            r_out_data   <= r_res_data;
            r_out_status <= r_res_status;
            r_out_count  <= r_cnt;
            r_out_full   <= is_full;
            r_out_empty  <= (r_cnt == '0);
        end
    end

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.full       = is_full;
        o_stat.pos_gt_cnt = pos_ext > r_cnt;
        o_stat.pos_ge_cnt = pos_ext >= r_cnt;
        o_stat.ins_last   = (r_idx - CW'(1)) == pos_ext;
        o_stat.rm_more    = (pos_ext + CW'(1)) < r_cnt;
        o_stat.rm_last    = (r_idx + CW'(2)) >= r_cnt;
    end

    assign o_data      = r_out_data;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;
    assign o_full_res  = r_out_full;
    assign o_empty_res = r_out_empty;

endmodule

### rtl/core/bsl_ctrl.sv
module bsl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  bsl_pkg::t_dp_stat i_stat,
    output bsl_pkg::t_dp_cmd  o_ctl
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DECODE    = 3'd1;
    localparam logic [2:0] S_INS_SHIFT = 3'd2;
    localparam logic [2:0] S_INS_LAST  = 3'd3;
    localparam logic [2:0] S_RM_DATA   = 3'd4;
    localparam logic [2:0] S_RM_SHIFT  = 3'd5;
    localparam logic [2:0] S_RD_DATA   = 3'd6;
    localparam logic [2:0] S_FINISH    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        o_ctl           = '0;
        o_ctl.rd_sel    = bsl_pkg::RA_POS;
        o_ctl.wr_sel    = bsl_pkg::WA_POS;
        o_ctl.idx_op    = bsl_pkg::IDX_HOLD;
        o_ctl.stat_code = bsl_pkg::ST_DONE;
        o_ctl.capture   = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_ctl.res_clr  = 1'b1;
                o_ctl.stat_set = 1'b1;
                n_state        = S_FINISH;
                case (i_stat.cmd)
                    bsl_pkg::CMD_APPEND: begin
                        if (i_stat.full) begin
                            o_ctl.stat_code = bsl_pkg::ST_FULL;
                        end else begin
                            o_ctl.wr_en   = 1'b1;
                            o_ctl.wr_sel  = bsl_pkg::WA_CNT;
                            o_ctl.cnt_inc = 1'b1;
                        end
                    end
                    bsl_pkg::CMD_INSERT: begin
                        if (i_stat.full) begin
                            o_ctl.stat_code = bsl_pkg::ST_FULL;
                        end else if (i_stat.pos_gt_cnt) begin
                            o_ctl.stat_code = bsl_pkg::ST_POS;
                        end else if (i_stat.pos_ge_cnt) begin
                            // insert at the end is an append
                            o_ctl.wr_en   = 1'b1;
                            o_ctl.cnt_inc = 1'b1;
                        end else begin
                            o_ctl.rd_en  = 1'b1;
                            o_ctl.rd_sel = bsl_pkg::RA_CNT_M1;
                            o_ctl.idx_op = bsl_pkg::IDX_LD_CNT;
                            n_state      = S_INS_SHIFT;
                        end
                    end
                    bsl_pkg::CMD_REMOVE: begin
                        if (i_stat.pos_ge_cnt) begin
                            o_ctl.stat_code = bsl_pkg::ST_POS;
                        end else begin
                            o_ctl.rd_en = 1'b1;
                            n_state     = S_RM_DATA;
                        end
                    end
                    bsl_pkg::CMD_READ: begin
                        if (i_stat.pos_ge_cnt) begin
                            o_ctl.stat_code = bsl_pkg::ST_POS;
                        end else begin
                            o_ctl.rd_en = 1'b1;
                            n_state     = S_RD_DATA;
                        end
                    end
                    bsl_pkg::CMD_WRITE: begin
                        if (i_stat.pos_ge_cnt) begin
                            o_ctl.stat_code = bsl_pkg::ST_POS;
                        end else begin
                            o_ctl.wr_en = 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_INS_SHIFT: begin
                // move entry idx-1 up to idx while fetching the one below
                o_ctl.wr_en       = 1'b1;
                o_ctl.wr_sel      = bsl_pkg::WA_IDX;
                o_ctl.wr_from_mem = 1'b1;
                o_ctl.idx_op      = bsl_pkg::IDX_DEC;
                if (i_stat.ins_last) begin
                    n_state = S_INS_LAST;
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = bsl_pkg::RA_IDX_M2;
                end
            end
            S_INS_LAST: begin
                o_ctl.wr_en   = 1'b1;
                o_ctl.cnt_inc = 1'b1;
                n_state       = S_FINISH;
            end
            S_RM_DATA: begin
                o_ctl.res_cap = 1'b1;
                o_ctl.idx_op  = bsl_pkg::IDX_LD_POS;
                if (i_stat.rm_more) begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = bsl_pkg::RA_POS_P1;
                    n_state      = S_RM_SHIFT;
                end else begin
                    o_ctl.cnt_dec = 1'b1;
                    n_state       = S_FINISH;
                end
            end
            S_RM_SHIFT: begin
                // move entry idx+1 down to idx while fetching the one above
                o_ctl.wr_en       = 1'b1;
                o_ctl.wr_sel      = bsl_pkg::WA_IDX;
                o_ctl.wr_from_mem = 1'b1;
                o_ctl.idx_op      = bsl_pkg::IDX_INC;
                if (i_stat.rm_last) begin
                    o_ctl.cnt_dec = 1'b1;
                    n_state       = S_FINISH;
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = bsl_pkg::RA_IDX_P2;
                end
            end
            S_RD_DATA: begin
                o_ctl.res_cap = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctl.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/bounded_shifting_list_unit.sv
// Ordered list of up to 256 signed 32-bit words with append, insert, remove, read and
// overwrite commands, one result word per command word. The entries sit in one memory
// with a single write port and a registered read port; insert and remove move the
// entries behind the position one per cycle through that port. A command word is taken
// only while the unit is idle, once the previous result has been loaded. The list is
// empty after reset, with no clearing pass; the capacity register resets to 256 and
// may be written at any time the unit is idle.
module bounded_shifting_list_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [bsl_pkg::CMD_BITS-1:0]         i_command,
    input  logic [bsl_pkg::POS_BITS-1:0]         i_position,
    input  logic signed [bsl_pkg::WORD_BITS-1:0] i_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [bsl_pkg::WORD_BITS-1:0] o_data,
    output logic [bsl_pkg::STAT_BITS-1:0]        o_status,
    output logic [bsl_pkg::CNT_BITS-1:0]         o_count,
    output logic                                 o_full_res,
    output logic                                 o_empty_res,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bsl_pkg::CAP_BITS-1:0]         i_cfg_data
);

    bsl_pkg::t_dp_cmd  ctl;
    bsl_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    bsl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    bsl_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_command   (i_command),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_full_res  (o_full_res),
        .o_empty_res (o_empty_res)
    );

endmodule

### rtl/core/bsl_checker.sv
`include "bounded_shifting_list_unit_defines.svh"

module bsl_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic signed [bsl_pkg::WORD_BITS-1:0] o_data,
    input logic [bsl_pkg::STAT_BITS-1:0]        o_status,
    input logic [bsl_pkg::CNT_BITS-1:0]         o_count,
    input logic                                 o_empty_res
);

    // one word in flight: the input side closes right after an accept
    `BSL_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "word accepted while another is in work")

    `BSL_ASSERT_NOW(a_empty_flag, i_clk, i_rst_n, o_out_valid, o_empty_res == (o_count == '0), "empty flag disagrees with count")

    `BSL_ASSERT_NOW(a_err_no_data, i_clk, i_rst_n, o_out_valid && (o_status != bsl_pkg::ST_DONE), o_data == '0, "failed command returned data")

    `BSL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_data) && $stable(o_count), "stalled result changed")

endmodule

bind bounded_shifting_list_unit bsl_checker u_bsl_checker (.*);

### tb/bsl_list_monitor.sv
module bsl_list_monitor
    import bsl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [CMD_BITS-1:0]  i_command,
    input  logic [POS_BITS-1:0]  i_position,
    input  t_word                i_value,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_word                i_data,
    input  logic [STAT_BITS-1:0] i_status,
    input  logic [CNT_BITS-1:0]  i_count,
    input  logic                 i_full_res,
    input  logic                 i_empty_res,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CAP_BITS-1:0]  i_cfg_data,
    output int                   o_err_count,
    output int                   o_pending,
    output int                   o_list_len
);

    typedef struct {
        t_word                data;
        logic [STAT_BITS-1:0] status;
        logic [CNT_BITS-1:0]  count;
        logic                 full_res;
        logic                 empty_res;
    } t_reply;

    // shadow copy of the list contents and the capacity register
    t_word               mirror_words [DEPTH];
    int unsigned         mirror_len;
    logic [CAP_BITS-1:0] mirror_cap;

    t_reply reply_q [$];
    t_reply want;
    int     error_tally;

    initial begin
        o_err_count = 0;
        o_pending   = 0;
        o_list_len  = 0;
        error_tally = 0;
        mirror_len  = 0;
        mirror_cap  = CAP_RESET;
    end

    function automatic t_reply apply_list_command(input logic [CMD_BITS-1:0] cmd,
                                                  input logic [POS_BITS-1:0] pos,
                                                  input t_word val);
        t_reply      r;
        int unsigned cap_eff;
        int unsigned p;
        int unsigned k;
        logic        at_limit;
        cap_eff  = (mirror_cap > DEPTH) ? DEPTH : mirror_cap;
        p        = pos;
        at_limit = (mirror_len >= cap_eff) || (mirror_len >= DEPTH);
        r.data   = '0;
        r.status = ST_DONE;
        case (cmd)
            CMD_APPEND: begin
                if (at_limit) begin
                    r.status = ST_FULL;
                end else begin
                    mirror_words[mirror_len] = val;
                    mirror_len++;
                end
            end
            CMD_INSERT: begin
                // full is reported ahead of a bad position
                if (at_limit) begin
                    r.status = ST_FULL;
                end else if (p > mirror_len) begin
                    r.status = ST_POS;
                end else begin
                    for (k = mirror_len; k > p; k--) begin
                        mirror_words[k] = mirror_words[k-1];
                    end
                    mirror_words[p] = val;
                    mirror_len++;
                end
            end
            CMD_REMOVE: begin
                if (p >= mirror_len) begin
                    r.status = ST_POS;
                end else begin
                    r.data = mirror_words[p];
                    for (k = p; k + 1 < mirror_len; k++) begin
                        mirror_words[k] = mirror_words[k+1];
                    end
                    mirror_len--;
                end
            end
            CMD_READ: begin
                if (p >= mirror_len) begin
                    r.status = ST_POS;
                end else begin
                    r.data = mirror_words[p];
                end
            end
            CMD_WRITE: begin
                if (p >= mirror_len) begin
                    r.status = ST_POS;
                end else begin
                    mirror_words[p] = val;
                end
            end
            default: begin
            end
        endcase
        r.count     = CNT_BITS'(mirror_len);
        r.full_res  = (mirror_len >= cap_eff);
        r.empty_res = (mirror_len == 0);
        return r;
    endfunction

    function automatic void check_field(input string name,
                                        input logic signed [63:0] exp_val,
                                        input logic signed [63:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
            error_tally++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mirror_len = 0;
            mirror_cap = CAP_RESET;
            reply_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (reply_q.size() == 0) begin
                    $error("result word with nothing outstanding: data %0d status %0d count %0d",
                           i_data, i_status, i_count);
                    error_tally++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("data", want.data, i_data);
                    check_field("status", want.status, i_status);
                    check_field("count", want.count, i_count);
                    check_field("full_res", want.full_res, i_full_res);
                    check_field("empty_res", want.empty_res, i_empty_res);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                mirror_cap = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                reply_q.push_back(apply_list_command(i_command, i_position, i_value));
            end
        end
        o_err_count <= error_tally;
        o_pending   <= reply_q.size();
        o_list_len  <= mirror_len;
    end

endmodule

### tb/bounded_shifting_list_unit_tb.sv
module bounded_shifting_list_unit_tb;
    import bsl_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;
    localparam int NUM_PHASES   = 10;

    // command codes the block treats as no-ops
    localparam logic [CMD_BITS-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_SPARE_LAST  = 3'd7;

    localparam t_word WORD_MIN = 32'sh8000_0000;
    localparam t_word WORD_MAX = 32'sh7fff_ffff;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic [CMD_BITS-1:0]  i_command   = '0;
    logic [POS_BITS-1:0]  i_position  = '0;
    t_word                i_value     = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CAP_BITS-1:0]  i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_word                o_data;
    logic [STAT_BITS-1:0] o_status;
    logic [CNT_BITS-1:0]  o_count;
    logic                 o_full_res;
    logic                 o_empty_res;
    logic                 o_cfg_ready;

    int err_count;
    int pending;
    int list_len;
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int idle_cycles  = 0;

    logic [CAP_BITS-1:0] cap_table  [NUM_PHASES] = '{1, 0, 4, 16, 300, 2, 64, 256, 9, 20};
    int                  fill_table [NUM_PHASES] = '{2, 2, 5, 12, 20, 3, 40, 10, 9, 16};

    bounded_shifting_list_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data      (o_data),
        .o_status    (o_status),
        .o_count     (o_count),
        .o_full_res  (o_full_res),
        .o_empty_res (o_empty_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    bsl_list_monitor u_list_monitor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_position  (i_position),
        .i_value     (i_value),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_data      (o_data),
        .i_status    (o_status),
        .i_count     (o_count),
        .i_full_res  (o_full_res),
        .i_empty_res (o_empty_res),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_list_len  (list_len)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= (rx_stall_pct != 0) && ($urandom_range(0, 99) < rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("bounded_shifting_list_unit_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end
            IDLE_SENDER: begin
                tx_gap_pct   = 78;
                rx_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                tx_gap_pct   = 0;
                rx_stall_pct = 78;
            end
            default: begin
                tx_gap_pct   = 25;
                rx_stall_pct = 25;
            end
        endcase
    endtask

    // valid stays high after acceptance so back-to-back words need no gap
    task automatic push_word(input logic [CMD_BITS-1:0] c, input logic [POS_BITS-1:0] p,
                             input t_word v);
        while ((tx_gap_pct != 0) && ($urandom_range(0, 99) < tx_gap_pct)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= c;
        i_position <= p;
        i_value    <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // list length from the monitor lags one word, good enough to aim positions
    task automatic random_words(input int n, input int fill_to);
        logic [CMD_BITS-1:0] c;
        logic [POS_BITS-1:0] p;
        t_word               v;
        int                  len;
        int                  r;
        logic                grow;
        repeat (n) begin
            len  = list_len;
            grow = (len < fill_to);
            r    = $urandom_range(0, 99);
            if (r < 4) begin
                c = CMD_SPARE_FIRST + CMD_BITS'($urandom_range(0, 2));
            end else if (r < (grow ? 50 : 25)) begin
                c = $urandom_range(0, 1) ? CMD_INSERT : CMD_APPEND;
            end else if (r < (grow ? 62 : 60)) begin
                c = CMD_REMOVE;
            end else if (r < 80) begin
                c = CMD_READ;
            end else begin
                c = CMD_WRITE;
            end
            if (len == 0 || $urandom_range(0, 9) == 0) begin
                p = POS_BITS'($urandom_range(0, 255));
            end else if (c == CMD_INSERT) begin
                p = POS_BITS'($urandom_range(0, (len > 255) ? 255 : len));
            end else begin
                p = POS_BITS'($urandom_range(0, len - 1));
            end
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0: v = WORD_MIN;
                    1: v = WORD_MAX;
                    2: v = '0;
                    default: v = '1;
                endcase
            end else begin
                v = $urandom;
            end
            push_word(c, p, v);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list, reset capacity
        push_word(CMD_READ, 0, 0);
        push_word(CMD_REMOVE, 0, 0);
        push_word(CMD_WRITE, 0, 1);
        push_word(CMD_INSERT, 1, 2);
        push_word(CMD_INSERT, 0, WORD_MAX);
        push_word(CMD_APPEND, 0, WORD_MIN);
        push_word(CMD_INSERT, 2, -1);            // position equal to count
        push_word(CMD_INSERT, 1, 32'sh1234_5678);
        push_word(CMD_READ, 3, 0);
        push_word(CMD_READ, 4, 0);
        push_word(CMD_WRITE, 2, 0);
        push_word(CMD_REMOVE, 0, 0);
        push_word(CMD_REMOVE, 2, 0);
        push_word(CMD_REMOVE, 255, 0);
        push_word(CMD_READ, 255, 0);
        push_word(CMD_SPARE_FIRST, 255, -1);
        push_word(CMD_SPARE_MID, 0, WORD_MAX);
        push_word(CMD_SPARE_LAST, 128, WORD_MIN);
        push_word(CMD_APPEND, 0, 32'sh5555_5555);
        push_word(CMD_WRITE, 0, 32'shAAAA_AAAA);

        // capacity dropped below the current count
        write_capacity(2);
        push_word(CMD_APPEND, 0, 7);
        push_word(CMD_INSERT, 200, 7);           // full wins over bad position
        push_word(CMD_REMOVE, 0, 0);
        push_word(CMD_REMOVE, 0, 0);
        push_word(CMD_APPEND, 0, -5);
        push_word(CMD_APPEND, 0, 9);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_capacity((ph == NUM_PHASES - 1) ? CAP_BITS'($urandom_range(1, 32))
                                                  : cap_table[ph]);
            set_idling(t_idle_mode'(ph % 4));
            random_words(45, fill_table[ph]);
        end

        // capacity beyond the store: fill all entries and work at the top end
        write_capacity(511);
        set_idling(IDLE_BOTH);
        while (list_len < DEPTH) push_word(CMD_APPEND, 0, $urandom);
        settle();
        push_word(CMD_APPEND, 0, 1);
        push_word(CMD_INSERT, 0, 1);
        push_word(CMD_READ, 255, 0);
        push_word(CMD_WRITE, 255, WORD_MIN);
        push_word(CMD_REMOVE, 0, 0);
        push_word(CMD_INSERT, 0, WORD_MAX);
        push_word(CMD_REMOVE, 255, 0);
        push_word(CMD_INSERT, 255, -1);
        push_word(CMD_READ, 128, 0);
        set_idling(IDLE_RECEIVER);
        random_words(25, DEPTH);

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("bounded_shifting_list_unit_tb: clean");
        end else begin
            $display("bounded_shifting_list_unit_tb: errors");
        end
        $finish;
    end

endmodule
